/* rtl/gpc_pkg.sv */
// Package for the grid path counter: payload widths, configuration types and the
// result record shared by the top level and the output buffer.
// No dependencies.
`default_nettype none

package gpc_pkg;

	localparam int WAYS_W = 64;
	localparam int SIZE_W = 7;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd10;
	localparam logic [SIZE_W-1:0] COLS_RESET = 7'd10;

	typedef struct packed {
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
		logic              restart;
	} gpc_cfg_t;

	typedef struct packed {
		logic [WAYS_W-1:0] ways;
		logic              sat;
		logic              last;
	} gpc_res_t;

endpackage

`default_nettype wire

/* rtl/gpc_if.sv */
// Valid/ready channel interfaces of the grid path counter: the cell request
// channel and the result channel. Depends on gpc_pkg.
`default_nettype none

interface gpc_in_if;
	logic valid;
	logic ready;
	logic cell_blocked;

	modport source (output valid, output cell_blocked, input ready);
	modport sink (input valid, input cell_blocked, output ready);
endinterface

interface gpc_out_if
	import gpc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [WAYS_W-1:0] ways_to_cell;
	logic              count_saturated;
	logic              is_final;

	modport source (output valid, output ways_to_cell, output count_saturated,
		output is_final, input ready);
	modport sink (input valid, input ways_to_cell, input count_saturated,
		input is_final, output ready);
endinterface

`default_nettype wire

/* rtl/gpc_cell.sv */
// One cell of the row buffer chain: holds one column count of the previous row
// and shifts toward the head on every accepted request. Depends on gpc_pkg.
`default_nettype none

module gpc_cell
	import gpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire logic              is_tail,
	input  wire logic [WAYS_W-1:0] new_count,
	input  wire logic [WAYS_W-1:0] next_count,
	output logic      [WAYS_W-1:0] count
);

	logic [WAYS_W-1:0] count_q;

	// The tail cell takes the freshly computed count; the others take their neighbor's.
	always_ff @(posedge clk) begin
		if (shift) begin
			count_q <= is_tail ? new_count : next_count;
		end
	end

	assign count = count_q;

endmodule

`default_nettype wire

/* rtl/gpc_regs.sv */
// APB configuration registers of the grid path counter (rows and columns in use).
// A write also restarts the grid position. Depends on gpc_pkg.
`default_nettype none

module gpc_regs
	import gpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output gpc_cfg_t               cfg
);

	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[SIZE_W-1:0];
				REG_COLS: cols_q <= pwdata[SIZE_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = APB_DW'(rows_q);
			REG_COLS: prdata = APB_DW'(cols_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.rows    = rows_q;
	assign cfg.cols    = cols_q;
	assign cfg.restart = wr_en;

endmodule

`default_nettype wire

/* rtl/gpc_out_buf.sv */
// Two-entry result buffer (output register plus skid register) that drives the
// result channel. Depends on gpc_pkg and gpc_if.
`default_nettype none

module gpc_out_buf
	import gpc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire gpc_res_t push_res,
	output logic          can_accept,
	gpc_out_if.source     out_ch
);

	gpc_res_t main_q;
	gpc_res_t skid_q;
	logic     main_vld_q;
	logic     skid_vld_q;
	logic     pop;

	assign pop        = main_vld_q && out_ch.ready;
	assign can_accept = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !main_vld_q) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= push;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_vld_q) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_res;
				end
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign out_ch.valid           = main_vld_q;
	assign out_ch.ways_to_cell    = main_q.ways;
	assign out_ch.count_saturated = main_q.sat;
	assign out_ch.is_final        = main_q.last;

	// The skid register only fills behind a waiting output register.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry held without an output entry");

	// A stalled full buffer keeps both entries.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !out_ch.ready) |=> (skid_vld_q && main_vld_q))
		else $error("full buffer lost an entry while stalled");

	// With no result taken and a new one pushed, the buffer cannot end up empty.
	a_push_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && can_accept) |=> main_vld_q)
		else $error("pushed result not held");

endmodule

`default_nettype wire

/* rtl/grid_path_counter.sv */
// Grid path counter: one cell per request in row-major order, one result per cell.
// Throughput: one cell per cycle while the skid entry is free, set by the single 64-bit
// add of the chain head and the left count; a two-entry output buffer keeps requests
// flowing while a result waits and registers each result as its request is accepted.
// Reset clears position, saturation flag and buffer valids; sizes reset to 10 by 10.
// No clearing pass: row buffer contents are not read before the first row rewrites them.
`default_nettype none

module grid_path_counter
	import gpc_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	gpc_in_if.sink                 in_ch,
	gpc_out_if.source              out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RSW  = $clog2(MAX_ROWS + 1);
	localparam int CSW  = $clog2(MAX_COLS + 1);
	localparam int SZ0  = (RSW > CSW) ? RSW : CSW;
	localparam int SZW  = (SZ0 > SIZE_W) ? SZ0 : SIZE_W;

	gpc_cfg_t cfg;

	gpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sizes of zero act as one; sizes above the maximum act as the maximum.
	logic [SZW-1:0] rows_ext;
	logic [SZW-1:0] cols_ext;
	logic [SZW-1:0] last_row_full;
	logic [SZW-1:0] last_col_full;
	logic [RIW-1:0] last_row;
	logic [CIW-1:0] last_col;

	assign rows_ext = SZW'(cfg.rows);
	assign cols_ext = SZW'(cfg.cols);

	always_comb begin
		if (rows_ext == '0) begin
			last_row_full = '0;
		end else if (rows_ext > SZW'(MAX_ROWS)) begin
			last_row_full = SZW'(MAX_ROWS - 1);
		end else begin
			last_row_full = rows_ext - SZW'(1);
		end
		if (cols_ext == '0) begin
			last_col_full = '0;
		end else if (cols_ext > SZW'(MAX_COLS)) begin
			last_col_full = SZW'(MAX_COLS - 1);
		end else begin
			last_col_full = cols_ext - SZW'(1);
		end
	end

	assign last_row = last_row_full[RIW-1:0];
	assign last_col = last_col_full[CIW-1:0];

	logic [RIW-1:0]    row_q;
	logic [CIW-1:0]    col_q;
	logic              sat_q;
	logic [WAYS_W-1:0] left_q;
	logic              accept;
	logic              buf_ready;

	assign in_ch.ready = buf_ready;
	assign accept      = in_ch.valid && buf_ready;

	// Row buffer as a shift chain: the head always holds the count above the current cell.
	logic [WAYS_W-1:0] chain_q [MAX_COLS];
	logic [WAYS_W-1:0] ways;

	for (genvar i = 0; i < MAX_COLS; i++) begin : g_chain
		logic [WAYS_W-1:0] next_count;
		if (i == MAX_COLS - 1) begin : g_end
			assign next_count = '0;
		end else begin : g_mid
			assign next_count = chain_q[i+1];
		end
		gpc_cell u_cell (
			.clk        (clk),
			.shift      (accept),
			.is_tail    (last_col == CIW'(i)),
			.new_count  (ways),
			.next_count (next_count),
			.count      (chain_q[i])
		);
	end

	logic [WAYS_W-1:0] up;
	logic [WAYS_W-1:0] left;
	logic [WAYS_W:0]   sum;
	logic              at_start;
	logic              sat_now;
	logic              final_cell;

	assign up         = (row_q != '0) ? chain_q[0] : '0;
	assign left       = (col_q != '0) ? left_q : '0;
	assign sum        = {1'b0, up} + {1'b0, left};
	assign at_start   = (row_q == '0) && (col_q == '0);
	assign sat_now    = !in_ch.cell_blocked && !at_start && sum[WAYS_W];
	assign final_cell = (row_q == last_row) && (col_q == last_col);

	always_comb begin
		if (in_ch.cell_blocked) begin
			ways = '0;
		end else if (at_start) begin
			ways = WAYS_W'(1);
		end else if (sum[WAYS_W]) begin
			ways = '1;
		end else begin
			ways = sum[WAYS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			sat_q <= 1'b0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
			sat_q <= 1'b0;
		end else if (accept) begin
			if (final_cell) begin
				row_q <= '0;
				col_q <= '0;
				sat_q <= 1'b0;
			end else begin
				sat_q <= sat_q || sat_now;
				if (col_q == last_col) begin
					col_q <= '0;
					row_q <= row_q + RIW'(1);
				end else begin
					col_q <= col_q + CIW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= ways;
		end
	end

	gpc_res_t res;

	assign res.ways = ways;
	assign res.sat  = sat_q || sat_now;
	assign res.last = final_cell;

	gpc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_res   (res),
		.can_accept (buf_ready),
		.out_ch     (out_ch)
	);

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col)
		else $error("column position beyond grid width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_row)
		else $error("row position beyond grid height");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.restart |=> (row_q == '0 && col_q == '0 && !sat_q))
		else $error("configuration write did not restart the grid");

	a_final_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_cell) |=> (row_q == '0 && col_q == '0 && !sat_q))
		else $error("grid did not wrap after its last cell");

endmodule

`default_nettype wire
